[rtl/crf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_pkg
// Shared types and constants for the clipped rectangle fill unit.
// ----------------------------------------------------------------------------
package crf_pkg;

   // Field and state widths
   localparam int DimW    = 14;   // clip limits, up to the largest surface dimension
   localparam int PosW    = 13;   // pixel positions, 0 .. MaxDim-1
   localparam int CoordW  = 16;
   localparam int ColorW  = 32;
   localparam int PitchW  = 16;
   localparam int BaseW   = 40;
   localparam int AddrW   = 41;
   localparam int CountW  = 3;
   localparam int CsrIdxW = 3;
   localparam int CsrW    = 40;

   // Largest usable surface dimension; bigger register values saturate
   localparam logic [DimW-1:0] MaxDim = 14'd8192;

   // Operation codes
   localparam logic OpStart = 1'b0;
   localparam logic OpStep  = 1'b1;

   // Register indexes
   localparam logic [CsrIdxW-1:0] RegSurfaceWidth  = 3'd0;
   localparam logic [CsrIdxW-1:0] RegSurfaceHeight = 3'd1;
   localparam logic [CsrIdxW-1:0] RegRowPitch      = 3'd2;
   localparam logic [CsrIdxW-1:0] RegFourBytePix   = 3'd3;
   localparam logic [CsrIdxW-1:0] RegSurfaceBase   = 3'd4;

   // Register reset values
   localparam logic [DimW-1:0]   ResetWidth  = 14'd1024;
   localparam logic [DimW-1:0]   ResetHeight = 14'd768;
   localparam logic [PitchW-1:0] ResetPitch  = 16'd4096;
   localparam logic              ResetFour   = 1'b1;
   localparam logic [BaseW-1:0]  ResetBase   = 40'd0;

   // Byte counts
   localparam logic [CountW-1:0] Bytes24 = 3'd3;
   localparam logic [CountW-1:0] Bytes32 = 3'd4;

   typedef struct packed {
      logic [DimW-1:0]   surface_width;
      logic [DimW-1:0]   surface_height;
      logic [PitchW-1:0] row_pitch;
      logic              four_byte_pixels;
      logic [BaseW-1:0]  surface_base;
   } cfg_type;

   typedef struct packed {
      logic                     operation;
      logic signed [CoordW-1:0] rect_x;
      logic signed [CoordW-1:0] rect_y;
      logic signed [CoordW-1:0] rect_w;
      logic signed [CoordW-1:0] rect_h;
      logic [ColorW-1:0]        fill_color;
   } req_item_type;

   // Clipped bounds of a start word
   typedef struct packed {
      logic            nonempty;
      logic [PosW-1:0] first_col;
      logic [PosW-1:0] first_row;
      logic [DimW-1:0] col_limit;
      logic [DimW-1:0] row_limit;
   } clip_type;

   // One pixel write waiting for its address
   typedef struct packed {
      logic [PosW-1:0]   row;
      logic [PosW-1:0]   col;
      logic [ColorW-1:0] color;
      logic              four_byte_pixels;
      logic [PitchW-1:0] row_pitch;
      logic [BaseW-1:0]  surface_base;
      logic              last;
   } job_type;

   // Walker status seen by the top level checks
   typedef struct packed {
      logic            fill_active;
      logic [PosW-1:0] cur_col;
      logic [PosW-1:0] cur_row;
      logic [DimW-1:0] col_limit;
      logic [DimW-1:0] row_limit;
   } walk_status_type;

endpackage

[rtl/crf_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_req_if
// Request channel: start and step words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface crf_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic signed [crf_pkg::CoordW-1:0] rect_x;
   logic signed [crf_pkg::CoordW-1:0] rect_y;
   logic signed [crf_pkg::CoordW-1:0] rect_w;
   logic signed [crf_pkg::CoordW-1:0] rect_h;
   logic [crf_pkg::ColorW-1:0]        fill_color;

   modport source (output valid, operation, rect_x, rect_y, rect_w, rect_h, fill_color,
                   input ready);
   modport sink   (input valid, operation, rect_x, rect_y, rect_w, rect_h, fill_color,
                   output ready);
endinterface

[rtl/crf_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_rsp_if
// Response channel: one pixel write word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface crf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [crf_pkg::AddrW-1:0]   write_address;
   logic [crf_pkg::ColorW-1:0]  write_data;
   logic [crf_pkg::CountW-1:0]  byte_count;
   logic                        last_of_fill;

   modport source (output valid, write_address, write_data, byte_count, last_of_fill,
                   input ready);
   modport sink   (input valid, write_address, write_data, byte_count, last_of_fill,
                   output ready);
endinterface

[rtl/crf_clip.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_clip
// Clips a signed request rectangle against the surface dimensions.
// ----------------------------------------------------------------------------
module crf_clip (
   input  crf_pkg::req_item_type item,
   input  logic [crf_pkg::DimW-1:0] surface_width,
   input  logic [crf_pkg::DimW-1:0] surface_height,
   output crf_pkg::clip_type clip
);

   logic signed [17:0] x0, y0, x1, y1, x1_clip, y1_clip, wl, hl;
   logic [crf_pkg::DimW-1:0] wl_sat, hl_sat;

   // Saturate the surface size at the largest dimension
   always_comb begin
      wl_sat = (surface_width  > crf_pkg::MaxDim) ? crf_pkg::MaxDim : surface_width;
      hl_sat = (surface_height > crf_pkg::MaxDim) ? crf_pkg::MaxDim : surface_height;
      wl     = $signed({4'b0000, wl_sat});
      hl     = $signed({4'b0000, hl_sat});
   end

   // Near edges clamp at zero, far edges at the surface size
   always_comb begin
      x0 = item.rect_x[15] ? 18'sd0 : $signed({{2{item.rect_x[15]}}, item.rect_x});
      y0 = item.rect_y[15] ? 18'sd0 : $signed({{2{item.rect_y[15]}}, item.rect_y});
      x1 = $signed({{2{item.rect_x[15]}}, item.rect_x})
         + $signed({{2{item.rect_w[15]}}, item.rect_w});
      y1 = $signed({{2{item.rect_y[15]}}, item.rect_y})
         + $signed({{2{item.rect_h[15]}}, item.rect_h});
      x1_clip = (x1 > wl) ? wl : x1;
      y1_clip = (y1 > hl) ? hl : y1;
   end

   // Bounds are only meaningful when the rectangle is not empty
   always_comb begin
      clip.nonempty  = (x0 < x1_clip) && (y0 < y1_clip);
      clip.first_col = x0[crf_pkg::PosW-1:0];
      clip.first_row = y0[crf_pkg::PosW-1:0];
      clip.col_limit = x1_clip[crf_pkg::DimW-1:0];
      clip.row_limit = y1_clip[crf_pkg::DimW-1:0];
   end

endmodule

[rtl/crf_walker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_walker
// Holds the fill bounds and raster position, and issues one pixel job per
// step word during an active fill into the job register.
// ----------------------------------------------------------------------------
module crf_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  crf_pkg::req_item_type item,
   input  crf_pkg::clip_type     clip,
   input  crf_pkg::cfg_type      cfg,
   input  logic                  job_take,
   output crf_pkg::job_type      job,
   output logic                  job_valid,
   output crf_pkg::walk_status_type status
);

   logic                       active_ff, active_in;
   logic [crf_pkg::PosW-1:0]   col_ff, col_in, row_ff, row_in, first_ff, first_in;
   logic [crf_pkg::DimW-1:0]   col_lim_ff, col_lim_in, row_lim_ff, row_lim_in;
   logic [crf_pkg::ColorW-1:0] color_ff, color_in;
   crf_pkg::job_type           job_ff, job_in;
   logic                       job_vld_ff, job_vld_in;
   logic                       step, start, row_end, last, issue;

   assign start = accept && (item.operation == crf_pkg::OpStart);
   assign step  = accept && (item.operation == crf_pkg::OpStep);
   assign issue = step && active_ff;

   // End-of-row and end-of-fill tests
   always_comb begin
      row_end = ({1'b0, col_ff} + 14'd1) >= col_lim_ff;
      last    = row_end && (({1'b0, row_ff} + 14'd1) >= row_lim_ff);
   end

   // Fill state update
   always_comb begin
      active_in  = active_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      first_in   = first_ff;
      col_lim_in = col_lim_ff;
      row_lim_in = row_lim_ff;
      color_in   = color_ff;
      if (start) begin
         color_in  = item.fill_color;
         active_in = clip.nonempty;
         if (clip.nonempty) begin
            first_in   = clip.first_col;
            col_in     = clip.first_col;
            row_in     = clip.first_row;
            col_lim_in = clip.col_limit;
            row_lim_in = clip.row_limit;
         end
      end else if (issue) begin
         if (last) begin
            active_in = 1'b0;
         end else if (row_end) begin
            col_in = first_ff;
            row_in = row_ff + 13'd1;
         end else begin
            col_in = col_ff + 13'd1;
         end
      end
   end

   // Job register: snapshot of the current pixel and per-step config
   always_comb begin
      job_in.row              = row_ff;
      job_in.col              = col_ff;
      job_in.color            = color_ff;
      job_in.four_byte_pixels = cfg.four_byte_pixels;
      job_in.row_pitch        = cfg.row_pitch;
      job_in.surface_base     = cfg.surface_base;
      job_in.last             = last;
      job_vld_in = issue ? 1'b1 : (job_take ? 1'b0 : job_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
         first_ff   <= '0;
         col_lim_ff <= '0;
         row_lim_ff <= '0;
         color_ff   <= '0;
         job_vld_ff <= 1'b0;
      end else begin
         active_ff  <= active_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         first_ff   <= first_in;
         col_lim_ff <= col_lim_in;
         row_lim_ff <= row_lim_in;
         color_ff   <= color_in;
         job_vld_ff <= job_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         job_ff <= job_in;
      end
   end

   assign job       = job_ff;
   assign job_valid = job_vld_ff;

   always_comb begin
      status.fill_active = active_ff;
      status.cur_col     = col_ff;
      status.cur_row     = row_ff;
      status.col_limit   = col_lim_ff;
      status.row_limit   = row_lim_ff;
   end

endmodule

[rtl/crf_address.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crf_address
// Forms the byte address, data and byte count of a pixel job and holds the
// result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module crf_address (
   input  logic             clock,
   input  logic             reset,
   input  crf_pkg::job_type job,
   input  logic             job_valid,
   input  logic             out_ready,
   output logic             job_take,
   output logic             out_valid,
   output logic [crf_pkg::AddrW-1:0]  write_address,
   output logic [crf_pkg::ColorW-1:0] write_data,
   output logic [crf_pkg::CountW-1:0] byte_count,
   output logic             last_of_fill
);

   logic                        out_vld_ff, out_vld_in, advance;
   logic [28:0]                 row_offset;
   logic [14:0]                 col_offset;
   logic [crf_pkg::AddrW-1:0]   addr_in, addr_ff;
   logic [crf_pkg::ColorW-1:0]  data_in, data_ff;
   logic [crf_pkg::CountW-1:0]  count_in, count_ff;
   logic                        last_ff;

   // The output register frees up when empty or when its word is taken
   assign advance  = !out_vld_ff || out_ready;
   assign job_take = advance && job_valid;

   // base + row*pitch + col*bytes; the address width holds the full sum
   always_comb begin
      row_offset = {16'd0, job.row} * {13'd0, job.row_pitch};
      col_offset = job.four_byte_pixels ? {job.col, 2'b00}
                                        : ({1'b0, job.col, 1'b0} + {2'b00, job.col});
      addr_in  = {1'b0, job.surface_base} + {12'd0, row_offset} + {26'd0, col_offset};
      data_in  = job.four_byte_pixels ? job.color : {8'h00, job.color[23:0]};
      count_in = job.four_byte_pixels ? crf_pkg::Bytes32 : crf_pkg::Bytes24;
      out_vld_in = advance ? job_valid : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         addr_ff  <= addr_in;
         data_ff  <= data_in;
         count_ff <= count_in;
         last_ff  <= job.last;
      end
   end

   assign out_valid     = out_vld_ff;
   assign write_address = addr_ff;
   assign write_data    = data_ff;
   assign byte_count    = count_ff;
   assign last_of_fill  = last_ff;

endmodule

[rtl/clipped_rectangle_fill_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_rectangle_fill_unit
// Clipped rectangle fill engine: one pixel write per step word during a fill.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries start words (operation 0: rectangle and color) and step
//   words (operation 1). A start clips the rectangle to the surface and arms
//   the fill; it gives no response. Each step while a fill is armed gives one
//   pixel write on rsp_port in raster order; the final one has last_of_fill
//   set. Steps while idle give nothing. A start during a fill replaces it.
//   csr_we/csr_index/csr_wdata write the surface registers; write them only
//   while no fill word is in flight. Clip bounds are taken at start, pitch,
//   base and pixel size at each step.
// Pipeline and throughput:
//   One word per cycle while rsp_port.ready is high. A step is held first in
//   the job register, then in the output register, which the row*pitch
//   multiply and the address add feed.
// Reset and stall:
//   Synchronous reset clears the fill state and both pipeline stages and
//   loads the register defaults. When rsp_port.ready is low the output word
//   holds; the job register still takes one more step, then req_port.ready
//   drops until the output moves.
// ----------------------------------------------------------------------------
module clipped_rectangle_fill_unit (
   input  logic                          clock,
   input  logic                          reset,
   crf_req_if.sink                       req_port,
   crf_rsp_if.source                     rsp_port,
   input  logic                          csr_we,
   input  logic [crf_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [crf_pkg::CsrW-1:0]      csr_wdata
);

   crf_pkg::cfg_type          cfg_ff, cfg_in;
   crf_pkg::req_item_type     item;
   crf_pkg::clip_type         clip;
   crf_pkg::job_type          job;
   crf_pkg::walk_status_type  status;
   logic                      job_valid, job_take, accept;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            crf_pkg::RegSurfaceWidth:  cfg_in.surface_width    = csr_wdata[crf_pkg::DimW-1:0];
            crf_pkg::RegSurfaceHeight: cfg_in.surface_height   = csr_wdata[crf_pkg::DimW-1:0];
            crf_pkg::RegRowPitch:      cfg_in.row_pitch        = csr_wdata[crf_pkg::PitchW-1:0];
            crf_pkg::RegFourBytePix:   cfg_in.four_byte_pixels = csr_wdata[0];
            crf_pkg::RegSurfaceBase:   cfg_in.surface_base     = csr_wdata[crf_pkg::BaseW-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.surface_width    <= crf_pkg::ResetWidth;
         cfg_ff.surface_height   <= crf_pkg::ResetHeight;
         cfg_ff.row_pitch        <= crf_pkg::ResetPitch;
         cfg_ff.four_byte_pixels <= crf_pkg::ResetFour;
         cfg_ff.surface_base     <= crf_pkg::ResetBase;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request word unpack and handshake
   always_comb begin
      item.operation  = req_port.operation;
      item.rect_x     = req_port.rect_x;
      item.rect_y     = req_port.rect_y;
      item.rect_w     = req_port.rect_w;
      item.rect_h     = req_port.rect_h;
      item.fill_color = req_port.fill_color;
   end

   assign req_port.ready = !job_valid || job_take;
   assign accept         = req_port.valid && req_port.ready;

   crf_clip u_clip (
      .item           (item),
      .surface_width  (cfg_ff.surface_width),
      .surface_height (cfg_ff.surface_height),
      .clip           (clip)
   );

   crf_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .clip      (clip),
      .cfg       (cfg_ff),
      .job_take  (job_take),
      .job       (job),
      .job_valid (job_valid),
      .status    (status)
   );

   crf_address u_address (
      .clock         (clock),
      .reset         (reset),
      .job           (job),
      .job_valid     (job_valid),
      .out_ready     (rsp_port.ready),
      .job_take      (job_take),
      .out_valid     (rsp_port.valid),
      .write_address (rsp_port.write_address),
      .write_data    (rsp_port.write_data),
      .byte_count    (rsp_port.byte_count),
      .last_of_fill  (rsp_port.last_of_fill)
   );

   // Checks
   a_active_in_bounds: assert property (@(posedge clock) disable iff (reset)
      status.fill_active |-> ({1'b0, status.cur_col} < status.col_limit)
                          && ({1'b0, status.cur_row} < status.row_limit))
      else $error("fill position outside its bounds");

   a_last_ends_fill: assert property (@(posedge clock) disable iff (reset)
      (accept && item.operation == crf_pkg::OpStep && status.fill_active
       && ({1'b0, status.cur_col} + 14'd1 >= status.col_limit)
       && ({1'b0, status.cur_row} + 14'd1 >= status.row_limit))
      |=> !status.fill_active)
      else $error("fill still active after its last pixel");

   a_output_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> $past(job_valid) || $past(rsp_port.valid))
      else $error("response word without a job");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_port.ready |-> job_valid && rsp_port.valid && !rsp_port.ready)
      else $error("request stalled with room in the pipeline");

endmodule
